/* hdl/qpe_pkg.sv */
package qpe_pkg;

  localparam int INDEX_ENTRIES = 64;
  localparam int IDX_W         = $clog2(INDEX_ENTRIES);
  localparam int RUN_LIMIT     = 62;
  localparam int RUN_W         = 6;
  localparam int PIX_W         = 32;
  localparam int BODY_BYTES    = 5;
  localparam int PAD_BYTES     = 8;
  localparam int GRP_BYTES     = 1 + BODY_BYTES + PAD_BYTES;
  localparam int GRP_CNT_W     = $clog2(GRP_BYTES + 1);

  localparam logic [7:0] OP_INDEX = 8'h00;
  localparam logic [7:0] OP_DIFF  = 8'h40;
  localparam logic [7:0] OP_LUMA  = 8'h80;
  localparam logic [7:0] OP_RUN   = 8'hc0;
  localparam logic [7:0] OP_RGB   = 8'hfe;
  localparam logic [7:0] OP_RGBA  = 8'hff;

  localparam logic [PIX_W-1:0] PIX_RESET = 32'h0000_00ff;

  // End marker, first byte in the low bits: seven zero bytes, then 0x01.
  localparam logic [8*PAD_BYTES-1:0] PAD_SEQ = 64'h0100_0000_0000_0000;

  typedef logic [PIX_W-1:0] pixel_t;
  typedef logic [IDX_W-1:0] idx_t;

  typedef struct packed {
    logic   valid;
    pixel_t px;
    logic   last;
    idx_t   hash;
    pixel_t entry;
    logic   entry_valid;
  } fetch_t;

  typedef struct packed {
    logic   fire;
    logic   we;
    idx_t   addr;
    pixel_t data;
    logic   clear;
  } idx_wr_t;

  typedef struct packed {
    logic                   load;
    logic [8*GRP_BYTES-1:0] bytes;
    logic [GRP_CNT_W-1:0]   count;
    logic                   img_end;
  } group_t;

  function automatic idx_t pixel_hash(pixel_t px);
    logic [11:0] s;
    s = 12'(px[31:24]) * 12'd3 + 12'(px[23:16]) * 12'd5 +
        12'(px[15:8]) * 12'd7 + 12'(px[7:0]) * 12'd11;
    return s[IDX_W-1:0];
  endfunction

endpackage

/* hdl/qpe_pix_if.sv */
interface qpe_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic       last_pixel;

  modport source (output valid, red, green, blue, alpha, last_pixel, input ready);
  modport sink (input valid, red, green, blue, alpha, last_pixel, output ready);
endinterface

/* hdl/qpe_byte_if.sv */
interface qpe_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       end_of_item;
  logic       end_of_image;

  modport source (output valid, code_byte, end_of_item, end_of_image, input ready);
  modport sink (input valid, code_byte, end_of_item, end_of_image, output ready);
endinterface

/* hdl/qpe_ram.sv */
module qpe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/qpe_fetch.sv */
module qpe_fetch (
  input  logic             clk,
  input  logic             rst_n,
  qpe_pix_if.sink          in_pixel,
  input  logic             cfg_we,
  input  logic             cfg_wdata,
  input  qpe_pkg::idx_wr_t wr,
  output qpe_pkg::fetch_t  fetch
);
  import qpe_pkg::*;

  logic                     four_ch_r;
  logic                     a_valid_r;
  pixel_t                   px_r;
  logic                     last_r;
  idx_t                     hash_r;
  logic                     fwd_r;
  pixel_t                   fwd_data_r;
  logic                     ent_valid_r;
  logic [INDEX_ENTRIES-1:0] valid_bits_r;

  logic   in_fire;
  pixel_t in_px;
  idx_t   in_hash;
  idx_t   rd_addr;
  pixel_t ram_rdata;
  logic   fwd_hit;

  assign in_pixel.ready = !a_valid_r || wr.fire;
  assign in_fire        = in_pixel.valid && in_pixel.ready;
  assign in_px          = {in_pixel.red, in_pixel.green, in_pixel.blue,
                           four_ch_r ? in_pixel.alpha : 8'hff};
  assign in_hash        = pixel_hash(in_px);

  // A stalled pixel keeps re-reading its own entry so the RAM output stays current.
  assign rd_addr = in_fire ? in_hash : hash_r;

  // The entry being written in this cycle is not yet visible at the RAM output.
  assign fwd_hit = wr.fire && wr.we && (wr.addr == in_hash);

  qpe_ram #(
    .WIDTH (PIX_W),
    .DEPTH (INDEX_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (wr.we),
    .waddr (wr.addr),
    .wdata (wr.data),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      four_ch_r    <= 1'b0;
      a_valid_r    <= 1'b0;
      valid_bits_r <= '0;
    end else begin
      if (cfg_we) begin
        four_ch_r <= cfg_wdata;
      end
      if (wr.fire) begin
        if (wr.clear) begin
          valid_bits_r <= '0;
        end else if (wr.we) begin
          valid_bits_r[wr.addr] <= 1'b1;
        end
      end
      if (in_fire) begin
        a_valid_r <= 1'b1;
      end else if (wr.fire) begin
        a_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      px_r       <= in_px;
      last_r     <= in_pixel.last_pixel;
      hash_r     <= in_hash;
      fwd_r      <= fwd_hit;
      fwd_data_r <= wr.data;
      if (wr.fire && wr.clear) begin
        ent_valid_r <= 1'b0;
      end else if (fwd_hit) begin
        ent_valid_r <= 1'b1;
      end else begin
        ent_valid_r <= valid_bits_r[in_hash];
      end
    end
  end

  always_comb begin
    fetch.valid       = a_valid_r;
    fetch.px          = px_r;
    fetch.last        = last_r;
    fetch.hash        = hash_r;
    fetch.entry       = fwd_r ? fwd_data_r : ram_rdata;
    fetch.entry_valid = ent_valid_r;
  end

endmodule

/* hdl/qpe_encode.sv */
module qpe_encode (
  input  logic             clk,
  input  logic             rst_n,
  input  qpe_pkg::fetch_t  fetch,
  input  logic             group_free,
  output qpe_pkg::idx_wr_t wr,
  output qpe_pkg::group_t  grp
);
  import qpe_pkg::*;

  pixel_t           prev_r;
  logic [RUN_W-1:0] run_r;

  logic [7:0]             r, g, b, a;
  logic [7:0]             dr, dg, db, dgr, dgb;
  logic                   same, hit, is_diff, is_luma, fire;
  logic [RUN_W-1:0]       run_inc, run_nxt;
  logic                   run_emit;
  logic [7:0]             run_byte;
  logic [8*BODY_BYTES-1:0] body;
  logic [2:0]             body_n;
  logic [GRP_CNT_W-1:0]   count;
  logic [8*GRP_BYTES-1:0] seq;

  assign {r, g, b, a} = fetch.px;
  assign dr  = r - prev_r[31:24];
  assign dg  = g - prev_r[23:16];
  assign db  = b - prev_r[15:8];
  assign dgr = dr - dg;
  assign dgb = db - dg;

  assign same    = (fetch.px == prev_r);
  assign hit     = ((fetch.entry_valid ? fetch.entry : '0) == fetch.px);
  assign run_inc = run_r + RUN_W'(1);

  assign is_diff = ($signed(dr) >= -8'sd2) && ($signed(dr) <= 8'sd1) &&
                   ($signed(dg) >= -8'sd2) && ($signed(dg) <= 8'sd1) &&
                   ($signed(db) >= -8'sd2) && ($signed(db) <= 8'sd1);
  assign is_luma = ($signed(dg) >= -8'sd32) && ($signed(dg) <= 8'sd31) &&
                   ($signed(dgr) >= -8'sd8) && ($signed(dgr) <= 8'sd7) &&
                   ($signed(dgb) >= -8'sd8) && ($signed(dgb) <= 8'sd7);

  always_comb begin
    run_emit = 1'b0;
    run_byte = OP_RUN;
    run_nxt  = '0;
    body     = '0;
    body_n   = 3'd0;
    wr.we    = 1'b0;
    if (same) begin
      // A run is cut at the length limit and at the end of the image.
      run_emit = (run_inc >= RUN_W'(RUN_LIMIT)) || fetch.last;
      run_byte = OP_RUN | {2'b00, run_inc - RUN_W'(1)};
      run_nxt  = run_emit ? '0 : run_inc;
    end else begin
      run_emit = (run_r != '0);
      run_byte = OP_RUN | {2'b00, run_r - RUN_W'(1)};
      if (hit) begin
        body   = 40'(OP_INDEX | {2'b00, fetch.hash});
        body_n = 3'd1;
      end else begin
        wr.we = 1'b1;
        if (a != prev_r[7:0]) begin
          body   = {a, b, g, r, OP_RGBA};
          body_n = 3'd5;
        end else if (is_diff) begin
          body   = 40'(OP_DIFF | {2'b00, dr[1:0] + 2'd2, dg[1:0] + 2'd2, db[1:0] + 2'd2});
          body_n = 3'd1;
        end else if (is_luma) begin
          body   = 40'({dgr[3:0] + 4'd8, dgb[3:0] + 4'd8, OP_LUMA | {2'b00, dg[5:0] + 6'd32}});
          body_n = 3'd2;
        end else begin
          body   = 40'({b, g, r, OP_RGB});
          body_n = 3'd4;
        end
      end
    end

    // Bytes are packed first-out in the low bits: run byte, chunk, then the end marker.
    seq = fetch.last ? (8*GRP_BYTES)'(PAD_SEQ) : '0;
    seq = (seq << {body_n, 3'b000}) | (8*GRP_BYTES)'(body);
    if (run_emit) begin
      seq = {seq[8*GRP_BYTES-9:0], run_byte};
    end
    count = GRP_CNT_W'(run_emit) + GRP_CNT_W'(body_n) +
            (fetch.last ? GRP_CNT_W'(PAD_BYTES) : '0);

    fire = fetch.valid && ((count == '0) || group_free);

    wr.fire  = fire;
    wr.we    = wr.we && fire;
    wr.addr  = fetch.hash;
    wr.data  = fetch.px;
    wr.clear = fetch.last;

    grp.load    = fire && (count != '0);
    grp.bytes   = seq;
    grp.count   = count;
    grp.img_end = fetch.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= PIX_RESET;
      run_r  <= '0;
    end else if (fire) begin
      if (fetch.last) begin
        prev_r <= PIX_RESET;
        run_r  <= '0;
      end else begin
        prev_r <= fetch.px;
        run_r  <= run_nxt;
      end
    end
  end

endmodule

/* hdl/qpe_serial.sv */
module qpe_serial (
  input  logic            clk,
  input  logic            rst_n,
  input  qpe_pkg::group_t grp,
  output logic            group_free,
  qpe_byte_if.source      out_byte
);
  import qpe_pkg::*;

  logic [8*GRP_BYTES-1:0] shift_r;
  logic [GRP_CNT_W-1:0]   cnt_r;
  logic                   img_end_r;
  logic                   out_fire;

  assign out_byte.valid        = (cnt_r != '0);
  assign out_byte.code_byte    = shift_r[7:0];
  assign out_byte.end_of_item  = (cnt_r == GRP_CNT_W'(1));
  assign out_byte.end_of_image = (cnt_r == GRP_CNT_W'(1)) && img_end_r;

  assign out_fire   = out_byte.valid && out_byte.ready;
  // The next group may load in the cycle the current one transfers its last byte.
  assign group_free = (cnt_r == '0) || ((cnt_r == GRP_CNT_W'(1)) && out_byte.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (grp.load) begin
      cnt_r <= grp.count;
    end else if (out_fire) begin
      cnt_r <= cnt_r - GRP_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (grp.load) begin
      shift_r   <= grp.bytes;
      img_end_r <= grp.img_end;
    end else if (out_fire) begin
      shift_r <= shift_r >> 8;
    end
  end

endmodule

/* hdl/qoi_pixel_encoder.sv */
// Each pixel is held in the fetch registers, then encoded and loaded into the output
// shift register. Throughput: one pixel per cycle while each pixel yields at most
// one byte and the output is ready. The output sends one byte per cycle while ready,
// so a pixel with more bytes holds the input. A run extension produces no byte.
// Reset (rst_n low, synchronous) clears the color index, the previous pixel, the
// run length and the channel mode; no clearing pass is needed after reset.
module qoi_pixel_encoder (
  input  logic       clk,
  input  logic       rst_n,
  qpe_pix_if.sink    in_pixel,
  qpe_byte_if.source out_byte,
  input  logic       cfg_we,
  input  logic       cfg_wdata
);
  import qpe_pkg::*;

  fetch_t  fetch;
  idx_wr_t wr;
  group_t  grp;
  logic    group_free;

  qpe_fetch u_fetch (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_pixel  (in_pixel),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .wr        (wr),
    .fetch     (fetch)
  );

  qpe_encode u_encode (
    .clk        (clk),
    .rst_n      (rst_n),
    .fetch      (fetch),
    .group_free (group_free),
    .wr         (wr),
    .grp        (grp)
  );

  qpe_serial u_serial (
    .clk        (clk),
    .rst_n      (rst_n),
    .grp        (grp),
    .group_free (group_free),
    .out_byte   (out_byte)
  );

endmodule

/* hdl/qpe_checker.sv */
module qpe_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] code_byte,
  input logic       end_of_item,
  input logic       end_of_image
);

  // The input only stalls behind a byte waiting at the output.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no byte pending at the output");

  // The closing byte of an image is the final marker byte and closes its pixel.
  a_image_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && end_of_image) |-> (end_of_item && code_byte == 8'h01))
    else $error("end of image on a byte other than the final marker");

  // Reset empties the output.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(code_byte) &&
                                   $stable(end_of_item) && $stable(end_of_image)))
    else $error("stalled output byte changed");

endmodule

bind qoi_pixel_encoder qpe_checker u_qpe_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_pixel.ready),
  .out_valid    (out_byte.valid),
  .out_ready    (out_byte.ready),
  .code_byte    (out_byte.code_byte),
  .end_of_item  (out_byte.end_of_item),
  .end_of_image (out_byte.end_of_image)
);

/* test/tb.sv */
module tb;
  import qpe_pkg::*;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
    logic       last;
  } pix_item_t;

  typedef struct packed {
    logic [7:0] code;
    logic       item_end;
    logic       image_end;
  } code_byte_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  qpe_pix_if  pix_if ();
  qpe_byte_if byte_if ();

  qoi_pixel_encoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_pixel  (pix_if),
    .out_byte  (byte_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Encoder state as the testbench tracks it.
  pixel_t index_mem [INDEX_ENTRIES];
  pixel_t prev_px;
  int     run_len;
  logic   four_ch;

  pix_item_t  pixel_q[$];
  code_byte_t predicted_bytes[$];
  pix_item_t  next_px;
  pix_item_t  gen_prev;
  pix_item_t  palette [8];
  code_byte_t rx_got;
  code_byte_t rx_want;

  int n_pushed;
  int n_accepted;
  int n_bytes;
  int n_images;
  int n_err;
  int send_idle_pct;
  int recv_stall_pct;
  int ph;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic void clear_image_model();
    foreach (index_mem[i]) index_mem[i] = '0;
    prev_px = 32'h0000_00ff;
    run_len = 0;
  endfunction

  function automatic void encode_pixel(input logic [7:0] r, g, b, a_in, input logic last);
    logic [7:0] a, dr, dg, db, dgr, dgb;
    logic [7:0] bytes_q[$];
    pixel_t     px;
    idx_t       h;
    code_byte_t cb;
    a = four_ch ? a_in : 8'hff;
    px = {r, g, b, a};
    if (px == prev_px) begin
      run_len++;
      if (run_len >= RUN_LIMIT || last) begin
        bytes_q.push_back(OP_RUN | 8'(run_len - 1));
        run_len = 0;
      end
    end else begin
      if (run_len > 0) begin
        bytes_q.push_back(OP_RUN | 8'(run_len - 1));
        run_len = 0;
      end
      h = idx_t'(int'(r) * 3 + int'(g) * 5 + int'(b) * 7 + int'(a) * 11);
      if (index_mem[h] == px) begin
        bytes_q.push_back(OP_INDEX | 8'(h));
      end else begin
        index_mem[h] = px;
        if (a != prev_px[7:0]) begin
          bytes_q.push_back(OP_RGBA);
          bytes_q.push_back(r);
          bytes_q.push_back(g);
          bytes_q.push_back(b);
          bytes_q.push_back(a);
        end else begin
          // Channel deltas wrap modulo 256; biasing them makes the range
          // checks plain unsigned compares.
          dr = r - prev_px[31:24];
          dg = g - prev_px[23:16];
          db = b - prev_px[15:8];
          dgr = dr - dg;
          dgb = db - dg;
          if (8'(dr + 8'd2) <= 3 && 8'(dg + 8'd2) <= 3 && 8'(db + 8'd2) <= 3) begin
            bytes_q.push_back(OP_DIFF | {2'b00, 2'(dr + 8'd2), 2'(dg + 8'd2),
                                         2'(db + 8'd2)});
          end else if (8'(dgr + 8'd8) <= 15 && 8'(dg + 8'd32) <= 63 &&
                       8'(dgb + 8'd8) <= 15) begin
            bytes_q.push_back(OP_LUMA | {2'b00, 6'(dg + 8'd32)});
            bytes_q.push_back({4'(dgr + 8'd8), 4'(dgb + 8'd8)});
          end else begin
            bytes_q.push_back(OP_RGB);
            bytes_q.push_back(r);
            bytes_q.push_back(g);
            bytes_q.push_back(b);
          end
        end
      end
    end
    prev_px = px;
    if (last) begin
      for (int k = 0; k < PAD_BYTES; k++) begin
        bytes_q.push_back(k == PAD_BYTES - 1 ? 8'h01 : 8'h00);
      end
      clear_image_model();
    end
    foreach (bytes_q[i]) begin
      cb.code = bytes_q[i];
      cb.item_end = (i == bytes_q.size() - 1);
      cb.image_end = last && (i == bytes_q.size() - 1);
      predicted_bytes.push_back(cb);
    end
  endfunction

  task automatic add_px(input logic [7:0] r, g, b, a, input logic last);
    pix_item_t p;
    p.r = r;
    p.g = g;
    p.b = b;
    p.a = a;
    p.last = last;
    pixel_q.push_back(p);
    n_pushed++;
  endtask

  // Waits until every pixel has been taken and every predicted byte has
  // come back, then lets the pipeline settle in case a run is still pending.
  task automatic drain();
    do @(posedge clk);
    while (n_accepted != n_pushed || predicted_bytes.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    four_ch = m;
  endtask

  // Images built from runs, small and luma-range steps, recent colors and
  // alpha changes, with occasional fully random pixels.
  task automatic random_phase(input int target);
    int         made;
    int         kind;
    int         reps;
    logic [7:0] dg;
    pix_item_t  p;
    made = 0;
    while (made < target) begin
      p = gen_prev;
      kind = $urandom_range(99);
      reps = 1;
      if (kind < 18) begin
        reps = $urandom_range(1, 4);
      end else if (kind < 20) begin
        reps = $urandom_range(58, 66);
      end else if (kind < 38) begin
        p.r = p.r + 8'($urandom_range(3)) - 8'd2;
        p.g = p.g + 8'($urandom_range(3)) - 8'd2;
        p.b = p.b + 8'($urandom_range(3)) - 8'd2;
      end else if (kind < 54) begin
        dg = 8'($urandom_range(63)) - 8'd32;
        p.g = p.g + dg;
        p.r = p.r + dg + 8'($urandom_range(15)) - 8'd8;
        p.b = p.b + dg + 8'($urandom_range(15)) - 8'd8;
      end else if (kind < 68) begin
        p = palette[$urandom_range(7)];
      end else if (kind < 78) begin
        p.a = 8'($urandom);
      end else begin
        p.r = 8'($urandom);
        p.g = 8'($urandom);
        p.b = 8'($urandom);
        if ($urandom_range(3) == 0) begin
          p.a = 8'($urandom);
        end
      end
      if (reps > target - made) begin
        reps = target - made;
      end
      palette[$urandom_range(7)] = p;
      for (int k = 0; k < reps; k++) begin
        add_px(p.r, p.g, p.b, p.a, (k == reps - 1) && ($urandom_range(99) < 5));
      end
      made += reps;
      gen_prev = p;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      pix_if.valid <= 1'b0;
    end else begin
      if (pix_if.valid && pix_if.ready) begin
        encode_pixel(pix_if.red, pix_if.green, pix_if.blue, pix_if.alpha,
                     pix_if.last_pixel);
        n_accepted++;
      end
      if (!pix_if.valid || pix_if.ready) begin
        if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_px = pixel_q.pop_front();
          pix_if.valid <= 1'b1;
          pix_if.red <= next_px.r;
          pix_if.green <= next_px.g;
          pix_if.blue <= next_px.b;
          pix_if.alpha <= next_px.a;
          pix_if.last_pixel <= next_px.last;
        end else begin
          pix_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      byte_if.ready <= 1'b0;
    end else begin
      if (byte_if.valid && byte_if.ready) begin
        rx_got.code = byte_if.code_byte;
        rx_got.item_end = byte_if.end_of_item;
        rx_got.image_end = byte_if.end_of_image;
        if (predicted_bytes.size() == 0) begin
          n_err++;
          if (n_err <= 10) begin
            $display("unexpected transfer: code %h eoi %b eoimg %b", rx_got.code,
                     rx_got.item_end, rx_got.image_end);
          end
        end else begin
          rx_want = predicted_bytes.pop_front();
          if (rx_got !== rx_want) begin
            n_err++;
            if (n_err <= 10) begin
              $display("byte %0d: expected code %h eoi %b eoimg %b, got code %h eoi %b eoimg %b",
                       n_bytes, rx_want.code, rx_want.item_end, rx_want.image_end,
                       rx_got.code, rx_got.item_end, rx_got.image_end);
            end
          end
          if (rx_want.image_end) begin
            n_images++;
          end
          n_bytes++;
        end
      end
      byte_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    pix_if.valid = 1'b0;
    pix_if.red = '0;
    pix_if.green = '0;
    pix_if.blue = '0;
    pix_if.alpha = '0;
    pix_if.last_pixel = 1'b0;
    byte_if.ready = 1'b0;
    n_pushed = 0;
    n_accepted = 0;
    n_bytes = 0;
    n_images = 0;
    n_err = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    four_ch = 1'b0;
    clear_image_model();
    gen_prev = '0;
    foreach (palette[i]) palette[i] = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Three-channel mode: a run from the reset pixel, each chunk type but RGBA, an
    // index hit, and images ending on a run, a run extension and a new pixel.
    add_px(8'h00, 8'h00, 8'h00, 8'h5a, 1'b0);
    add_px(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    add_px(8'h01, 8'h00, 8'hff, 8'h00, 1'b0);
    add_px(8'd18, 8'd20, 8'd26, 8'h00, 1'b0);
    add_px(8'd200, 8'd10, 8'd100, 8'h00, 1'b0);
    add_px(8'hff, 8'hff, 8'hff, 8'hff, 1'b0);
    add_px(8'h01, 8'h00, 8'hff, 8'h00, 1'b0);
    add_px(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    add_px(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    add_px(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    add_px(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    add_px(8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
    add_px(8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
    add_px(8'hff, 8'hff, 8'hff, 8'h00, 1'b1);
    // A long run of one color reaches the run length limit, and the image
    // ends one pixel into the next run.
    for (int k = 0; k < 64; k++) begin
      add_px(8'd40, 8'd50, 8'd60, 8'h00, k == 63);
    end
    drain();

    // Four channels: the all-zero pixel hits the cleared index, then
    // alpha changes force RGBA chunks, including alpha at both extremes.
    write_mode(1'b1);
    add_px(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    add_px(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    add_px(8'd10, 8'd20, 8'd30, 8'd128, 1'b0);
    add_px(8'd10, 8'd20, 8'd30, 8'hff, 1'b0);
    add_px(8'd9, 8'd19, 8'd29, 8'hff, 1'b0);
    add_px(8'hff, 8'h00, 8'd128, 8'h00, 1'b0);
    drain();

    // Back to three channels inside the same image: alpha jumps to 255.
    write_mode(1'b0);
    add_px(8'hff, 8'h00, 8'd128, 8'h00, 1'b0);
    add_px(8'hff, 8'h00, 8'd128, 8'h00, 1'b1);
    drain();

    for (ph = 0; ph < 8; ph++) begin
      write_mode(ph[0] ^ ph[2]);
      case (ph % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 54;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 54;
        end
        default: begin
          send_idle_pct = 11;
          recv_stall_pct = 11;
        end
      endcase
      random_phase(18);
      drain();
    end

    $display("Encoded %0d pixels into %0d checked bytes across %0d complete images,",
             n_accepted, n_bytes, n_images);
    $display("in both channel modes with sender gaps and receiver stalls (%0d mismatches).",
             n_err);
    if (n_err == 0 && predicted_bytes.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("Timed out with %0d bytes still outstanding", predicted_bytes.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
